[rtl/core/sfc_pkg.sv]
// Shared types for the scatter fragment coalescer: command codes, the input
// beat, the transfer state and the per-beat decision flags. No dependencies.
`default_nettype none

package sfc_pkg;

   typedef enum logic {
      CMD_START    = 1'b0,
      CMD_FRAGMENT = 1'b1
   } sfc_cmd_type;

   typedef struct packed {
      sfc_cmd_type command;
      logic [47:0] total_bytes;
      logic [47:0] src_offset;
      logic [31:0] frag_len;
      logic        record;
   } sfc_item_type;

   typedef struct packed {
      logic [47:0] expected_total;
      logic [47:0] consumed_total;
      logic        last_valid;
      logic [47:0] last_area_offset;
      logic [47:0] last_dest_offset;
      logic [47:0] last_len;
   } sfc_state_type;

   typedef struct packed {
      logic ok;
      logic merged;
   } sfc_flags_type;

endpackage

`default_nettype wire

[rtl/core/sfc_step.sv]
// Next-state logic for one beat of the scatter fragment coalescer.
// Depends on sfc_pkg.
`default_nettype none

module sfc_step (
   input  sfc_pkg::sfc_state_type state,
   input  sfc_pkg::sfc_item_type  item,
   output sfc_pkg::sfc_state_type state_next,
   output sfc_pkg::sfc_flags_type flags
);
   import sfc_pkg::*;

   logic [48:0] consumed_sum;
   logic [48:0] area_end;
   logic [48:0] dest_end;
   logic        overrun;
   logic        contiguous;

   // Full-precision sums: one bit of headroom so nothing wraps.
   assign consumed_sum = {1'b0, state.consumed_total} + {17'b0, item.frag_len};
   assign overrun      = consumed_sum > {1'b0, state.expected_total};
   assign area_end     = {1'b0, state.last_area_offset} + {1'b0, state.last_len};
   assign dest_end     = {1'b0, state.last_dest_offset} + {1'b0, state.last_len};
   assign contiguous   = state.last_valid
                         && (area_end == {1'b0, item.src_offset})
                         && (dest_end == {1'b0, state.consumed_total});

   always_comb begin
      state_next   = state;
      flags.ok     = 1'b1;
      flags.merged = 1'b0;
      unique case (item.command)
         CMD_START: begin
            state_next                = '0;
            state_next.expected_total = item.total_bytes;
         end
         CMD_FRAGMENT: begin
            priority if (item.frag_len == 32'd0) begin
               // empty fragment: accept, change nothing
            end else if (overrun) begin
               flags.ok = 1'b0;
            end else begin
               if (item.record) begin
                  if (contiguous) begin
                     state_next.last_len = state.last_len + {16'b0, item.frag_len};
                     flags.merged        = 1'b1;
                  end else begin
                     state_next.last_valid       = 1'b1;
                     state_next.last_area_offset = item.src_offset;
                     state_next.last_dest_offset = state.consumed_total;
                     state_next.last_len         = {16'b0, item.frag_len};
                  end
               end
               state_next.consumed_total = consumed_sum[47:0];
            end
         end
         default: begin
            state_next = state;
         end
      endcase
   end

endmodule

`default_nettype wire

[rtl/core/scatter_fragment_coalescer_unit.sv]
// Top level of the scatter fragment coalescer: input register, step logic
// and result register. Depends on sfc_pkg and sfc_step.
`default_nettype none

// Counts the payload bytes of one receive transfer and, with record set,
// coalesces fragments into a single held scatter copy operation. A start
// beat (command 0) loads the expected total, clears the consumed count and
// drops the held operation. A fragment beat with record set either extends
// the held operation, when both its area span and destination span continue
// it, or replaces it with a new one whose destination is the current
// consumed count. Zero-length fragments are accepted without effect; a
// fragment that would overrun the expected total is rejected (ok = 0) and
// changes nothing. Every request beat yields exactly one response beat, in
// order. Throughput is one beat per cycle while rsp_ready keeps the response
// register draining: the beat sits in an input register, and add/compare
// logic (three 49-bit adds and compares) updates the transfer state and
// loads the response register. rsp_valid rises once the beat moves from the
// input register to the response register. The state update of one beat is
// visible to the next beat in the following cycle, so back-to-back beats
// chain with no bubble. req_ready drops only while both the input and
// response registers hold beats and rsp_ready is low.

module scatter_fragment_coalescer_unit (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_command,
   input  wire logic [47:0] req_expected_bytes,
   input  wire logic [47:0] req_area_offset,
   input  wire logic [31:0] req_frag_len,
   input  wire logic        req_record,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_ok,
   output logic             rsp_op_valid,
   output logic             rsp_merged,
   output logic [47:0]      rsp_op_area_offset,
   output logic [47:0]      rsp_op_dest_offset,
   output logic [47:0]      rsp_op_len,
   output logic [47:0]      rsp_consumed_bytes
);
   import sfc_pkg::*;

   // input register
   logic          item_valid_ff;
   logic          item_valid_in;
   sfc_item_type  item_ff;
   sfc_item_type  item_in;

   // transfer state
   sfc_state_type state_ff;
   sfc_state_type state_in;
   sfc_state_type state_next;
   sfc_flags_type flags;

   // response register
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   sfc_flags_type rsp_flags_ff;
   sfc_state_type rsp_state_ff;

   logic          req_take;
   logic          advance;

   // Move the held beat forward when the response slot is free or draining.
   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   sfc_step u_step (
      .state      (state_ff),
      .item       (item_ff),
      .state_next (state_next),
      .flags      (flags)
   );

   always_comb begin
      item_in.command     = sfc_cmd_type'(req_command);
      item_in.total_bytes = req_expected_bytes;
      item_in.src_offset  = req_area_offset;
      item_in.frag_len    = req_frag_len;
      item_in.record      = req_record;

      // input slot: load on a new beat, empty on advance, else hold
      priority if (req_take) begin
         item_valid_in = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end else begin
         item_valid_in = item_valid_ff;
      end

      // commit the state only when the beat moves to the response register
      state_in = advance ? state_next : state_ff;

      priority if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         state_ff      <= state_in;
      end
   end

   // payload registers: no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
      if (advance) begin
         rsp_flags_ff <= flags;
         rsp_state_ff <= state_next;
      end
   end

   // Held op fields are zero whenever last_valid is clear, so drive directly.
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_flags_ff.ok;
   assign rsp_merged         = rsp_flags_ff.merged;
   assign rsp_op_valid       = rsp_state_ff.last_valid;
   assign rsp_op_area_offset = rsp_state_ff.last_area_offset;
   assign rsp_op_dest_offset = rsp_state_ff.last_dest_offset;
   assign rsp_op_len         = rsp_state_ff.last_len;
   assign rsp_consumed_bytes = rsp_state_ff.consumed_total;

   // consumed count never passes the expected total
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      state_ff.consumed_total <= state_ff.expected_total)
      else $error("consumed count exceeds expected total");

   // a rejected fragment leaves the transfer state untouched
   a_reject_holds: assert property (@(posedge clock) disable iff (reset)
      (advance && !flags.ok) |=> $stable(state_ff))
      else $error("rejected fragment changed state");

   // a merge needs a held operation and an accepted fragment
   a_merge_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_merged) |-> (rsp_op_valid && rsp_ok))
      else $error("merge reported without a valid accepted operation");

   // without a held operation its fields read as zero
   a_op_zero: assert property (@(posedge clock) disable iff (reset)
      !state_ff.last_valid |-> (state_ff.last_len == 48'd0
         && state_ff.last_area_offset == 48'd0 && state_ff.last_dest_offset == 48'd0))
      else $error("held operation fields nonzero while invalid");

endmodule

`default_nettype wire
